>>> hdl/lfuwbc_pkg.sv
// Shared types and constants for the LFU write-back cluster cache controller.
// No dependencies; compile first.
package lfuwbc_pkg;

    localparam int SECTOR_W    = 18;
    localparam int CLUSTER_W   = 17;
    localparam int COUNT_W     = 16;
    localparam int SLOT_OUT_W  = 3;
    localparam int DIVISOR_W   = 8;                    // holds up to 255 sectors per cluster
    localparam int DIV_SHIFT   = SECTOR_W + DIVISOR_W; // reciprocal precision
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_FLUSH_ONE = 2'd2,
        OP_FLUSH_ALL = 2'd3
    } op_t;

    // Decoded request handed from front end to back end.
    typedef struct packed {
        op_t                  op;
        logic [CLUSTER_W-1:0] cluster;
        logic                 sub_sector;
        logic                 free_buffer;
    } req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

endpackage

>>> hdl/lfuwbc_req_if.sv
// Request channel: valid/ready handshake plus request payload.
// Depends on lfuwbc_pkg.
interface lfuwbc_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic [lfuwbc_pkg::SECTOR_W-1:0] sector;
    logic                            free_buffer;

    modport source (output valid, output operation, output sector, output free_buffer,
                    input ready);
    modport sink   (input valid, input operation, input sector, input free_buffer,
                    output ready);
endinterface

>>> hdl/lfuwbc_rsp_if.sv
// Result channel: valid/ready handshake plus result payload.
// Depends on lfuwbc_pkg.
interface lfuwbc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [lfuwbc_pkg::SLOT_OUT_W-1:0] slot;
    logic                              sub_sector;
    logic                              fill_needed;
    logic [lfuwbc_pkg::CLUSTER_W-1:0]  fill_cluster;
    logic                              writeback_needed;
    logic [lfuwbc_pkg::CLUSTER_W-1:0]  writeback_cluster;
    logic                              slot_found;
    logic                              last;

    modport source (output valid, output hit, output slot, output sub_sector,
                    output fill_needed, output fill_cluster, output writeback_needed,
                    output writeback_cluster, output slot_found, output last,
                    input ready);
    modport sink   (input valid, input hit, input slot, input sub_sector,
                    input fill_needed, input fill_cluster, input writeback_needed,
                    input writeback_cluster, input slot_found, input last,
                    output ready);
endinterface

>>> hdl/lfuwbc_front.sv
// Front end: accepts requests and splits the sector into cluster and sub-sector.
// Three-stage pipeline (reciprocal multiply, back-multiply, correction).
// Depends on lfuwbc_pkg and lfuwbc_req_if.
module lfuwbc_front #(
    parameter int SECTORS_PER_CLUSTER = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    lfuwbc_req_if.sink         req,
    output logic               item_valid,
    input  logic               item_ready,
    output lfuwbc_pkg::req_t   item
);
    import lfuwbc_pkg::*;

    localparam int PROD_W = SECTOR_W + DIV_SHIFT + 1;
    localparam int QD_W   = SECTOR_W + DIVISOR_W;
    localparam logic [DIV_SHIFT:0] RECIP =
        (DIV_SHIFT + 1)'((64'd1 << DIV_SHIFT) / SECTORS_PER_CLUSTER);
    localparam logic [DIVISOR_W-1:0] DIVISOR = DIVISOR_W'(SECTORS_PER_CLUSTER);

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SECTOR_W-1:0]  sec1_reg, sec2_reg;
    op_t                  op1_reg, op2_reg;
    logic                 fb1_reg, fb2_reg;
    logic [SECTOR_W-1:0]  q0_reg;
    logic [QD_W-1:0]      qd_reg;
    req_t                 item_reg;

    logic [SECTOR_W-1:0]  q0_next;
    logic [QD_W-1:0]      rem0;
    logic [SECTOR_W-1:0]  quot;
    logic [QD_W-1:0]      rem;
    req_t                 item_next;

    // whole pipeline holds while the last stage cannot hand off
    assign en        = !v3_reg || item_ready;
    assign req.ready = en;

    always_comb
    begin
        q0_next = prod_reg[DIV_SHIFT +: SECTOR_W];
        // estimate is the true quotient or one below it
        rem0 = QD_W'(sec2_reg) - qd_reg;
        if (rem0 >= QD_W'(DIVISOR))
        begin
            quot = q0_reg + SECTOR_W'(1);
            rem  = rem0 - QD_W'(DIVISOR);
        end
        else
        begin
            quot = q0_reg;
            rem  = rem0;
        end
        item_next.op          = op2_reg;
        item_next.cluster     = quot[CLUSTER_W-1:0];
        item_next.sub_sector  = rem[0];
        item_next.free_buffer = fb2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(req.sector) * PROD_W'(RECIP);
            sec1_reg <= req.sector;
            op1_reg  <= op_t'(req.operation);
            fb1_reg  <= req.free_buffer;
            q0_reg   <= q0_next;
            qd_reg   <= QD_W'(q0_next) * QD_W'(DIVISOR);
            sec2_reg <= sec1_reg;
            op2_reg  <= op1_reg;
            fb2_reg  <= fb1_reg;
            item_reg <= item_next;
        end
    end

    assign item_valid = v3_reg;
    assign item       = item_reg;

endmodule

>>> hdl/lfuwbc_queue.sv
// Short request queue between the front and back ends.
// Depends on lfuwbc_pkg.
module lfuwbc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  lfuwbc_pkg::req_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output lfuwbc_pkg::req_t pop_data
);
    import lfuwbc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    req_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/lfuwbc_back.sv
// Back end: tag lookup, LFU victim scan, slot state update and result register.
// Depends on lfuwbc_pkg and lfuwbc_rsp_if.
module lfuwbc_back #(
    parameter int SLOTS = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  lfuwbc_pkg::req_t item,
    lfuwbc_rsp_if.source     rsp
);
    import lfuwbc_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  sub_sector;
        logic                  fill_needed;
        logic [CLUSTER_W-1:0]  fill_cluster;
        logic                  writeback_needed;
        logic [CLUSTER_W-1:0]  writeback_cluster;
        logic                  slot_found;
        logic                  last;
    } rsp_t;

    back_state_t          state_reg, state_next;
    req_t                 cur_reg, cur_next;
    logic [SLOT_W-1:0]    sel_reg, sel_next;
    logic [SLOT_W-1:0]    scan_reg, scan_next;
    logic [COUNT_W-1:0]   best_reg, best_next;
    logic                 found_reg, found_next;
    logic                 victim_reg, victim_next;

    logic [SLOTS-1:0]     valid_reg;
    logic [SLOTS-1:0]     dirty_reg;
    logic [COUNT_W-1:0]   count_reg [SLOTS];
    logic [CLUSTER_W-1:0] cluster_reg [SLOTS];

    logic                 out_valid_reg;
    rsp_t                 out_reg;
    rsp_t                 rsp_next;
    logic                 out_free;
    logic                 fire;

    logic [SLOTS-1:0]     match_vec;
    logic                 any_match, any_empty;
    logic [SLOT_W-1:0]    hit_idx, empty_idx;

    logic [SLOT_W-1:0]    rd_idx;
    logic [COUNT_W-1:0]   rd_cnt;
    logic                 rd_valid, rd_dirty;
    logic [CLUSTER_W-1:0] rd_cluster;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    logic                 upd_en, upd_tag;
    logic                 new_valid, new_dirty;
    logic [COUNT_W-1:0]   new_count, inc_count;

    // parallel tag compare, first match wins; highest empty slot wins
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = 0; i < SLOTS; i++)
            match_vec[i] = valid_reg[i] && (cluster_reg[i] == cur_reg.cluster);
        for (int i = SLOTS - 1; i >= 0; i--)
            if (match_vec[i])
                hit_idx = SLOT_W'(i);
        for (int i = 0; i < SLOTS; i++)
            if (!valid_reg[i])
                empty_idx = SLOT_W'(i);
        any_match = |match_vec;
        any_empty = ~&valid_reg;
    end

    // one read port into the slot state
    assign rd_idx     = (state_reg == BK_SCAN) ? scan_reg : sel_reg;
    assign rd_cnt     = count_reg[rd_idx];
    assign rd_valid   = valid_reg[rd_idx];
    assign rd_dirty   = dirty_reg[rd_idx];
    assign rd_cluster = cluster_reg[rd_idx];
    assign slot_ext   = {{SLOT_OUT_W{1'b0}}, sel_reg};
    assign inc_count  = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
    assign out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        sel_next    = sel_reg;
        scan_next   = scan_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        victim_next = victim_reg;
        item_ready  = 1'b0;
        fire        = 1'b0;
        rsp_next    = '0;
        upd_en      = 1'b0;
        upd_tag     = 1'b0;
        new_valid   = rd_valid;
        new_dirty   = rd_dirty;
        new_count   = rd_cnt;

        case (state_reg)
            BK_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cur_next   = item;
                    state_next = BK_LOOKUP;
                end
            end

            BK_LOOKUP:
            begin
                victim_next = 1'b0;
                found_next  = any_match;
                state_next  = BK_EMIT;
                case (cur_reg.op)
                    OP_READ, OP_WRITE:
                    begin
                        if (any_match)
                            sel_next = hit_idx;
                        else if (any_empty)
                            sel_next = empty_idx;
                        else
                        begin
                            scan_next   = '0;
                            victim_next = 1'b1;
                            state_next  = BK_SCAN;
                        end
                    end
                    OP_FLUSH_ONE:
                        sel_next = any_match ? hit_idx : '0;
                    default:
                        sel_next = '0;
                endcase
            end

            BK_SCAN:
            begin
                // strict less-than keeps the first slot among equal counts
                if ((scan_reg == '0) || (rd_cnt < best_reg))
                begin
                    best_next = rd_cnt;
                    sel_next  = scan_reg;
                end
                if (scan_reg == LAST_SLOT)
                    state_next = BK_EMIT;
                else
                    scan_next = scan_reg + SLOT_W'(1);
            end

            BK_EMIT:
            begin
                fire = out_free;
                rsp_next.slot = slot_ext[SLOT_OUT_W-1:0];
                rsp_next.last = 1'b1;
                case (cur_reg.op)
                    OP_READ, OP_WRITE:
                    begin
                        upd_en              = fire;
                        rsp_next.sub_sector = cur_reg.sub_sector;
                        new_valid           = 1'b1;
                        if (found_reg)
                        begin
                            rsp_next.hit = 1'b1;
                            new_dirty    = rd_dirty || (cur_reg.op == OP_WRITE);
                            new_count    = inc_count;
                        end
                        else
                        begin
                            upd_tag                    = 1'b1;
                            rsp_next.fill_needed       = 1'b1;
                            rsp_next.fill_cluster      = cur_reg.cluster;
                            rsp_next.writeback_needed  = victim_reg && rd_dirty;
                            rsp_next.writeback_cluster =
                                (victim_reg && rd_dirty) ? rd_cluster : '0;
                            new_dirty                  = (cur_reg.op == OP_WRITE);
                            new_count                  = COUNT_W'(1);
                        end
                    end
                    default:
                    begin
                        // flush one (when found) and flush all share the slot update
                        upd_en = fire && ((cur_reg.op == OP_FLUSH_ALL) || found_reg);
                        if ((cur_reg.op == OP_FLUSH_ALL) || found_reg)
                        begin
                            rsp_next.writeback_needed  = rd_dirty;
                            rsp_next.writeback_cluster = rd_dirty ? rd_cluster : '0;
                        end
                        else
                            rsp_next.slot = '0;
                        new_dirty = 1'b0;
                        if (cur_reg.free_buffer)
                        begin
                            new_valid = 1'b0;
                            new_count = '0;
                        end
                        if (cur_reg.op == OP_FLUSH_ALL)
                        begin
                            rsp_next.slot_found = rd_valid;
                            rsp_next.last       = (sel_reg == LAST_SLOT);
                        end
                        else
                            rsp_next.slot_found = found_reg;
                    end
                endcase

                if (fire)
                begin
                    if ((cur_reg.op == OP_FLUSH_ALL) && (sel_reg != LAST_SLOT))
                        sel_next = sel_reg + SLOT_W'(1);
                    else
                        state_next = BK_IDLE;
                end
            end

            default:
                state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sel_reg       <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            victim_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            scan_reg   <= scan_next;
            found_reg  <= found_next;
            victim_reg <= victim_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        best_reg <= best_next;
        if (fire)
            out_reg <= rsp_next;
        if (upd_en && upd_tag)
            cluster_reg[sel_reg] <= cur_reg.cluster;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
                count_reg[i] <= '0;
        end
        else if (upd_en)
        begin
            valid_reg[sel_reg] <= new_valid;
            dirty_reg[sel_reg] <= new_dirty;
            count_reg[sel_reg] <= new_count;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.hit               = out_reg.hit;
    assign rsp.slot              = out_reg.slot;
    assign rsp.sub_sector        = out_reg.sub_sector;
    assign rsp.fill_needed       = out_reg.fill_needed;
    assign rsp.fill_cluster      = out_reg.fill_cluster;
    assign rsp.writeback_needed  = out_reg.writeback_needed;
    assign rsp.writeback_cluster = out_reg.writeback_cluster;
    assign rsp.slot_found        = out_reg.slot_found;
    assign rsp.last              = out_reg.last;

    // a cluster never sits in two valid slots
    a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("cluster cached in more than one slot");

    // eviction only happens with every slot occupied
    a_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT) && victim_reg |-> valid_reg[sel_reg])
        else $error("evicting an empty slot");

    // a write leaves its slot valid and dirty
    a_write_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cur_reg.op == OP_WRITE) |=>
            dirty_reg[$past(sel_reg)] && valid_reg[$past(sel_reg)])
        else $error("written slot not marked dirty");

    // a freeing flush of a slot leaves it empty and clean
    a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire && upd_en && cur_reg.free_buffer &&
            ((cur_reg.op == OP_FLUSH_ONE) || (cur_reg.op == OP_FLUSH_ALL)) |=>
            !valid_reg[$past(sel_reg)] && !dirty_reg[$past(sel_reg)])
        else $error("freed slot still valid or dirty");

endmodule

>>> hdl/lfu_writeback_cluster_cache_ctrl.sv
// Top level of the LFU write-back cluster cache controller.
// Depends on lfuwbc_pkg, lfuwbc_req_if, lfuwbc_rsp_if, lfuwbc_front,
// lfuwbc_queue and lfuwbc_back.
//
// Throughput: the back end handles one request at a time (pop, lookup, result),
//   adding a use-count scan over all slots when a victim must be chosen; flush-all
//   walks every slot (one result per cycle while the result side keeps up).
// Reset (async, active low) empties all slots and clears dirty bits, use counts,
//   queue and pipeline. Tags are not reset; no clearing pass is needed.
module lfu_writeback_cluster_cache_ctrl #(
    parameter int SLOTS               = 6,
    parameter int SECTORS_PER_CLUSTER = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    lfuwbc_req_if.sink   req,
    lfuwbc_rsp_if.source rsp
);
    import lfuwbc_pkg::*;

    // Front end -> queue: decoded item (cluster number, sub-sector, op).
    logic fr_valid, fr_ready;
    req_t fr_item;

    // Queue -> back end.
    logic bk_valid, bk_ready;
    req_t bk_item;

    // The front end splits the sector with a reciprocal multiply and one
    // correction step; it keeps accepting while the back end is busy, up to
    // the three pipeline stages plus the queue.
    lfuwbc_front #(
        .SECTORS_PER_CLUSTER (SECTORS_PER_CLUSTER)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    lfuwbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_item)
    );

    // The back end owns all slot state. It handles one item at a time: tag
    // compare across all slots in parallel, then either a direct result or
    // a walk over the use counts, one slot a cycle, to find the victim.
    // Results leave through a registered output stage.
    lfuwbc_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (bk_valid),
        .item_ready (bk_ready),
        .item       (bk_item),
        .rsp        (rsp)
    );

endmodule

>>> bench/lfu_writeback_cluster_cache_ctrl_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the LFU write-back cluster cache controller.
// Depends on lfuwbc_pkg, lfuwbc_req_if, lfuwbc_rsp_if and the controller RTL.
module lfu_writeback_cluster_cache_ctrl_tb;
    import lfuwbc_pkg::*;

    localparam int SLOTS_N      = 6;
    localparam int SPC          = 2;        // sectors per cluster
    localparam int RANDOM_ITEMS = 140;
    localparam int REPEAT_HITS  = 8;        // hits that lift one slot's use count
    localparam int HOLD_CYCLES  = 150;

    // One result item as seen on the rsp channel.
    typedef struct packed {
        logic                 hit;
        logic [2:0]           slot;
        logic                 sub_sector;
        logic                 fill_needed;
        logic [CLUSTER_W-1:0] fill_cluster;
        logic                 writeback_needed;
        logic [CLUSTER_W-1:0] writeback_cluster;
        logic                 slot_found;
        logic                 last;
    } cache_result_t;

    // Shadow copy of the tag/dirty/use-count store. Each accepted request is
    // run through the same replacement policy, and the results it must cause
    // are queued in order for the result-side monitor.
    class slot_policy_tracker;
        logic                 slot_valid [SLOTS_N];
        logic [CLUSTER_W-1:0] slot_tag   [SLOTS_N];
        logic                 slot_dirty [SLOTS_N];
        logic [COUNT_W-1:0]   slot_uses  [SLOTS_N];
        cache_result_t        pending_results [$];
        int mismatches;
        int unexpected;
        int checked;
        int reported;

        function new();
            for (int i = 0; i < SLOTS_N; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_tag[i]   = '0;
                slot_dirty[i] = 1'b0;
                slot_uses[i]  = '0;
            end
            mismatches = 0;
            unexpected = 0;
            checked    = 0;
            reported   = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function int find_tag(logic [CLUSTER_W-1:0] cl);
            int s;
            s = -1;
            for (int i = 0; i < SLOTS_N; i++)
                if (s < 0 && slot_valid[i] && slot_tag[i] == cl)
                    s = i;
            return s;
        endfunction

        // Write back if dirty, clear dirty, optionally release the slot.
        function cache_result_t flush_entry(int s, logic free_buf);
            cache_result_t r;
            r = '0;
            r.slot = 3'(s);
            if (slot_dirty[s])
            begin
                r.writeback_needed  = 1'b1;
                r.writeback_cluster = slot_tag[s];
                slot_dirty[s]       = 1'b0;
            end
            if (free_buf)
            begin
                slot_valid[s] = 1'b0;
                slot_uses[s]  = '0;
                slot_dirty[s] = 1'b0;
            end
            return r;
        endfunction

        function void accept_request(op_t op, logic [SECTOR_W-1:0] sector, logic free_buf);
            cache_result_t        r;
            logic [CLUSTER_W-1:0] cl;
            logic                 sub;
            int                   s;
            logic                 was_valid;
            cl  = CLUSTER_W'(int'(sector) / SPC);
            sub = 1'(int'(sector) % SPC);
            r   = '0;
            case (op)
                OP_READ, OP_WRITE:
                begin
                    s = find_tag(cl);
                    if (s >= 0)
                        r.hit = 1'b1;
                    else
                    begin
                        // highest-numbered empty slot wins
                        for (int i = 0; i < SLOTS_N; i++)
                            if (!slot_valid[i])
                                s = i;
                        if (s < 0)
                        begin
                            // first slot with the lowest use count
                            s = 0;
                            for (int i = 1; i < SLOTS_N; i++)
                                if (slot_uses[i] < slot_uses[s])
                                    s = i;
                            if (slot_dirty[s])
                            begin
                                r.writeback_needed  = 1'b1;
                                r.writeback_cluster = slot_tag[s];
                            end
                        end
                        slot_valid[s]  = 1'b1;
                        slot_tag[s]    = cl;
                        slot_dirty[s]  = 1'b0;
                        slot_uses[s]   = '0;
                        r.fill_needed  = 1'b1;
                        r.fill_cluster = cl;
                    end
                    if (op == OP_WRITE)
                        slot_dirty[s] = 1'b1;
                    if (slot_uses[s] != COUNT_MAX)
                        slot_uses[s] = slot_uses[s] + 1'b1;
                    r.slot       = 3'(s);
                    r.sub_sector = sub;
                    r.last       = 1'b1;
                    pending_results.push_back(r);
                end
                OP_FLUSH_ONE:
                begin
                    s = find_tag(cl);
                    if (s >= 0)
                    begin
                        r            = flush_entry(s, free_buf);
                        r.slot_found = 1'b1;
                    end
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
                default:
                begin
                    for (int i = 0; i < SLOTS_N; i++)
                    begin
                        was_valid    = slot_valid[i];
                        r            = flush_entry(i, free_buf);
                        r.slot_found = was_valid;
                        r.last       = (i == SLOTS_N - 1);
                        pending_results.push_back(r);
                    end
                end
            endcase
        endfunction

        function string show(cache_result_t r);
            return $sformatf("hit=%0b slot=%0d sub=%0b fill=%0b/%05h wb=%0b/%05h found=%0b last=%0b",
                             r.hit, r.slot, r.sub_sector, r.fill_needed, r.fill_cluster,
                             r.writeback_needed, r.writeback_cluster, r.slot_found, r.last);
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            if (pending_results.size() == 0)
            begin
                unexpected++;
                if (reported < 10)
                    $display("[%0t] result with nothing pending: %s", $time, show(got));
                reported++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.hit !== want.hit || got.slot !== want.slot
                || got.sub_sector !== want.sub_sector || got.fill_needed !== want.fill_needed
                || got.fill_cluster !== want.fill_cluster
                || got.writeback_needed !== want.writeback_needed
                || got.writeback_cluster !== want.writeback_cluster
                || got.slot_found !== want.slot_found || got.last !== want.last)
            begin
                mismatches++;
                if (reported < 10)
                begin
                    $display("[%0t] result mismatch", $time);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
                reported++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lfuwbc_req_if req_ch ();
    lfuwbc_rsp_if rsp_ch ();

    lfu_writeback_cluster_cache_ctrl #(
        .SLOTS               (SLOTS_N),
        .SECTORS_PER_CLUSTER (SPC)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    slot_policy_tracker tracker = new();

    // Receiver control, shared between the stimulus and the ready process.
    int   hold_off_cycles = 0;   // long stall requested by the stimulus
    logic sink_steady     = 1'b0; // force ready high (eviction-order run)
    int   ops_sent [4];
    logic [CLUSTER_W-1:0] cluster_pool [12];

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: ends a run that has not finished within the time limit.
    initial
    begin
        #20_000_000;
        $display("[%0t] watchdog expired, %0d results still pending", $time,
                 tracker.outstanding());
        $display("lfu_writeback_cluster_cache_ctrl verification failed");
        $finish;
    end

    // Result monitor: sample on the rising edge, check every accepted item.
    always @(posedge clk)
    begin
        cache_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.hit               = rsp_ch.hit;
            got.slot              = rsp_ch.slot;
            got.sub_sector        = rsp_ch.sub_sector;
            got.fill_needed       = rsp_ch.fill_needed;
            got.fill_cluster      = rsp_ch.fill_cluster;
            got.writeback_needed  = rsp_ch.writeback_needed;
            got.writeback_cluster = rsp_ch.writeback_cluster;
            got.slot_found        = rsp_ch.slot_found;
            got.last              = rsp_ch.last;
            tracker.check_result(got);
        end
    end

    // Receiver: cycles through its own stall patterns, picking a new random
    // mode when the current one runs out. A requested hold-off overrides
    // everything and is counted down here on each falling edge.
    initial
    begin
        int sink_mode;
        int mode_left;
        int phase;
        sink_mode     = 0;
        mode_left     = 60;
        phase         = 0;
        rsp_ch.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_off_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (sink_steady)
                rsp_ch.ready <= 1'b1;
            else
            begin
                case (sink_mode)
                    0: rsp_ch.ready <= 1'b1;                            // no stalls
                    1: rsp_ch.ready <= ($urandom_range(0, 99) < 60);    // random stalls
                    2: rsp_ch.ready <= ((phase % 5) < 3);               // periodic stalls
                    default: rsp_ch.ready <= ($urandom_range(0, 99) < 25);
                endcase
                mode_left--;
                if (mode_left == 0)
                begin
                    sink_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(40, 120);
                end
            end
        end
    end

    // Present one request from a falling edge, hold it until the block
    // takes it, then return on the next falling edge. valid stays high so
    // that back-to-back calls form a burst.
    task automatic offer_request(input op_t op, input logic [SECTOR_W-1:0] sector,
                                 input logic free_buf);
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.sector      <= sector;
        req_ch.free_buffer <= free_buf;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.accept_request(op, sector, free_buf);
        ops_sent[op]++;
        @(negedge clk);
    endtask

    // Sender gap (n > 0) with valid low; payload wiggles while valid is low.
    task automatic idle_sender(input int n);
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= 2'($urandom);
        req_ch.sector      <= SECTOR_W'($urandom);
        req_ch.free_buffer <= 1'($urandom);
        repeat (n) @(negedge clk);
    endtask

    // Stop offering until every expected result has come back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [SECTOR_W-1:0] sector_of(logic [CLUSTER_W-1:0] cl, int sub);
        return SECTOR_W'(int'(cl) * SPC + sub);
    endfunction

    // Mostly accesses to a small working set (twice the slot count) so that
    // hits, evictions and dirty write-backs are common; the rest is arbitrary
    // sectors that nearly always miss.
    task automatic random_request(output op_t op, output logic [SECTOR_W-1:0] sector,
                                  output logic free_buf);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            op = OP_READ;
        else if (roll < 80)
            op = OP_WRITE;
        else if (roll < 93)
            op = OP_FLUSH_ONE;
        else
            op = OP_FLUSH_ALL;
        if ($urandom_range(0, 99) < 88)
            sector = sector_of(cluster_pool[$urandom_range(0, 11)], $urandom_range(0, SPC - 1));
        else
            sector = SECTOR_W'($urandom_range(0, (1 << SECTOR_W) - 1));
        // keep full invalidations rare so the cache stays populated
        if (op == OP_FLUSH_ALL)
            free_buf = ($urandom_range(0, 99) < 30);
        else
            free_buf = 1'($urandom_range(0, 1));
    endtask

    initial
    begin
        op_t                 op;
        logic [SECTOR_W-1:0] sector;
        logic                free_buf;
        int                  sent;
        int                  burst;
        int                  gap;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_READ;
        req_ch.sector      = '0;
        req_ch.free_buffer = 1'b0;
        for (int i = 0; i < 4; i++)
            ops_sent[i] = 0;
        cluster_pool[0] = '0;
        cluster_pool[1] = '1;
        cluster_pool[2] = 17'h15555;
        cluster_pool[3] = 17'h0AAAA;
        for (int i = 4; i < 12; i++)
            cluster_pool[i] = CLUSTER_W'($urandom_range(0, (1 << CLUSTER_W) - 1));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- Directed part ----
        // Fill from an empty cache: misses land in the highest empty slot,
        // including the lowest and highest sector numbers.
        offer_request(OP_READ,  18'd0,      1'b0);
        offer_request(OP_WRITE, 18'h3FFFF,  1'b1);   // top sector, odd sub-sector
        offer_request(OP_READ,  18'd1,      1'b0);   // hit, sub-sector 1
        offer_request(OP_WRITE, 18'd3,      1'b0);
        offer_request(OP_READ,  18'd4,      1'b1);   // free_buffer ignored on reads
        offer_request(OP_WRITE, 18'd6,      1'b0);
        offer_request(OP_READ,  18'd9,      1'b0);   // last empty slot
        // Cache full: victim is the first slot with the lowest use count,
        // clean victim first, then a dirty one forcing a write-back.
        offer_request(OP_WRITE, 18'd11,     1'b0);
        offer_request(OP_READ,  18'd13,     1'b0);
        offer_request(OP_READ,  18'd15,     1'b0);
        // Flush one: dirty hit kept, miss, another miss with release, clean hit.
        offer_request(OP_FLUSH_ONE, 18'h3FFFE, 1'b0);
        offer_request(OP_FLUSH_ONE, 18'd100,   1'b1);
        offer_request(OP_FLUSH_ONE, 18'd11,    1'b1);
        offer_request(OP_FLUSH_ONE, 18'd0,     1'b0);
        // Re-access after flush, then a write miss that evicts a slot.
        offer_request(OP_WRITE, 18'h3FFFF,  1'b0);
        offer_request(OP_WRITE, 18'd200,    1'b0);
        offer_request(OP_WRITE, 18'd2,      1'b0);
        // Flush all without and with release, then flush an almost empty cache.
        offer_request(OP_FLUSH_ALL, 18'd0,  1'b0);
        offer_request(OP_WRITE, 18'd13,     1'b0);
        offer_request(OP_FLUSH_ALL, 18'd0,  1'b1);
        offer_request(OP_WRITE, 18'd77,     1'b1);
        offer_request(OP_FLUSH_ALL, 18'd5,  1'b0);
        offer_request(OP_FLUSH_ONE, 18'd77, 1'b1);
        wait_for_drain();

        // ---- Eviction order ----
        // Hammer one cluster so its count stands above the rest, then force
        // evictions; the hammered slot must outlive the fresh fills.
        sink_steady = 1'b1;
        for (int i = 0; i < REPEAT_HITS; i++)
            offer_request(OP_READ, sector_of(cluster_pool[0], i % SPC), 1'b0);
        for (int i = 0; i < 2 * SLOTS_N; i++)
            offer_request(i % 2 ? OP_WRITE : OP_READ, sector_of(CLUSTER_W'(5000 + i), 0), 1'b0);
        offer_request(OP_READ, sector_of(cluster_pool[0], 1), 1'b0);
        wait_for_drain();
        sink_steady = 1'b0;

        // ---- Random part ----
        // Bursts of random length with random gaps; one long receiver
        // hold-off with the sender still pushing, and one full drain pause.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                random_request(op, sector, free_buf);
                offer_request(op, sector, free_buf);
                sent++;
                if (sent == 50)
                    hold_off_cycles = HOLD_CYCLES;
                if (sent == 100)
                    wait_for_drain();
            end
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle_sender(gap);
        end
        idle_sender(1);

        // Wait out the results, then a margin for anything spurious.
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("run covered %0d reads, %0d writes, %0d single flushes, %0d full flushes;",
                 ops_sent[OP_READ], ops_sent[OP_WRITE], ops_sent[OP_FLUSH_ONE],
                 ops_sent[OP_FLUSH_ALL]);
        $display("%0d results checked incl. LFU eviction order and a %0d-cycle output stall",
                 tracker.checked, HOLD_CYCLES);
        if (tracker.mismatches == 0 && tracker.unexpected == 0 && tracker.outstanding() == 0)
            $display("lfu_writeback_cluster_cache_ctrl verification clean");
        else
        begin
            $display("%0d mismatches, %0d unexpected results, %0d missing results",
                     tracker.mismatches, tracker.unexpected, tracker.outstanding());
            $display("lfu_writeback_cluster_cache_ctrl verification failed");
        end
        $finish;
    end

endmodule
